[src/kfe_pkg.sv]
// shared types, constants and defaults for the knapsack fitness evaluator
package kfe_pkg;

  localparam int unsigned MAX_ITEMS_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF  = 16;

  localparam int unsigned SUM_W   = 26;
  localparam int unsigned TOTAL_W = 36;

  localparam logic [SUM_W-1:0]   SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};
  localparam logic [SUM_W-1:0]   PENALTY_SCORE = SUM_W'(1);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_GENE = 1'b1
  } kfe_cmd_e;

  typedef struct packed {
    logic [SUM_W-1:0] weight;
    logic [SUM_W-1:0] value;
    logic             last_chrom;
  } kfe_sums_t;

endpackage

[src/knapsack_fitness_evaluator.sv]
// knapsack fitness evaluator top level: request handshake, capacity register
//
// Load requests (cmd 0) write one weight and value entry into the item tables;
// gene requests (cmd 1) step through a chromosome one bit at a time. Every
// gene request that carries last_gene yields one result at the output once it
// has passed the table read, accumulate and score stages: the chromosome score
// (value sum, or 1 when the weight sum is above capacity), the population best
// and the saturating population total. One request is taken per cycle unless
// the input stalls, set by the single table read and the two sum adds per gene;
// the path is table ram read, accumulate stage, score stage, result register.
// Gene and load requests keep flowing while a result waits in the output
// register; the input stalls only when a second result is ready behind a held
// one. The tables have no reset, so every gene position used must be loaded
// first. Capacity sits at byte address 0 and should be written while no request is in flight.
module knapsack_fitness_evaluator #(
  parameter int unsigned MAX_ITEMS   = kfe_pkg::MAX_ITEMS_DEF,
  parameter int unsigned WEIGHT_BITS = kfe_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned VALUE_BITS  = kfe_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [9:0]                  item_index_i,
  input  logic [15:0]                 item_weight_i,
  input  logic [15:0]                 item_value_i,
  input  logic                        gene_i,
  input  logic                        last_gene_i,
  input  logic                        last_chromosome_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kfe_pkg::SUM_W-1:0]   chrom_score_o,
  output logic                        overweight_o,
  output logic [kfe_pkg::SUM_W-1:0]   best_score_o,
  output logic [kfe_pkg::TOTAL_W-1:0] total_score_o,
  output logic                        population_done_o
);

  logic [kfe_pkg::SUM_W-1:0] capacity_q;
  logic                      cfg_we, hold, acc, fin_valid;
  kfe_pkg::kfe_sums_t        fin;

  // single register, every word address maps to capacity
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = 32'(capacity_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (cfg_we) begin
      capacity_q <= pwdata[kfe_pkg::SUM_W-1:0];
    end
  end

  // freeze the pipe only when a finished result cannot enter the output
  assign hold       = fin_valid && out_valid_o && out_stall_i;
  assign in_stall_o = hold;
  assign acc        = in_valid_i && !hold;

  kfe_gene #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_gene (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (!hold),
    .acc_i             (acc),
    .cmd_i             (cmd_i),
    .item_index_i      (item_index_i),
    .item_weight_i     (item_weight_i),
    .item_value_i      (item_value_i),
    .gene_i            (gene_i),
    .last_gene_i       (last_gene_i),
    .last_chromosome_i (last_chromosome_i),
    .fin_valid_o       (fin_valid),
    .fin_o             (fin)
  );

  kfe_score u_score (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (!hold),
    .fin_valid_i       (fin_valid),
    .fin_i             (fin),
    .capacity_i        (capacity_q),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .chrom_score_o     (chrom_score_o),
    .overweight_o      (overweight_o),
    .best_score_o      (best_score_o),
    .total_score_o     (total_score_o),
    .population_done_o (population_done_o)
  );

  // overweight chromosomes carry the penalty score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overweight_o |-> chrom_score_o == kfe_pkg::PENALTY_SCORE)
    else $error("overweight result without penalty score");

  // best covers the current score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_score_o >= chrom_score_o)
    else $error("best score below chromosome score");

  // total covers the best score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_score_o >= kfe_pkg::TOTAL_W'(best_score_o))
    else $error("total score below best score");

endmodule

[src/kfe_ram.sv]
// generic single-port ram with registered read
module kfe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/kfe_gene.sv]
// item tables, gene position and per-chromosome weight and value sums
module kfe_gene #(
  parameter int unsigned MAX_ITEMS   = kfe_pkg::MAX_ITEMS_DEF,
  parameter int unsigned WEIGHT_BITS = kfe_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned VALUE_BITS  = kfe_pkg::VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              acc_i,
  input  logic              cmd_i,
  input  logic [9:0]        item_index_i,
  input  logic [15:0]       item_weight_i,
  input  logic [15:0]       item_value_i,
  input  logic              gene_i,
  input  logic              last_gene_i,
  input  logic              last_chromosome_i,
  output logic              fin_valid_o,
  output kfe_pkg::kfe_sums_t fin_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);
  localparam int unsigned GP_W   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WADD_W =
      ((WEIGHT_BITS > kfe_pkg::SUM_W) ? WEIGHT_BITS : kfe_pkg::SUM_W) + 1;
  localparam int unsigned VADD_W =
      ((VALUE_BITS > kfe_pkg::SUM_W) ? VALUE_BITS : kfe_pkg::SUM_W) + 1;

  logic [GP_W-1:0]          gp_q, gp_d;
  logic                     s1_valid_q;
  logic                     s1_gene_q, s1_last_gene_q, s1_last_chrom_q;
  logic [kfe_pkg::SUM_W-1:0] wsum_q, wsum_d, vsum_q, vsum_d;
  logic                     fin_valid_q, fin_valid_d;
  kfe_pkg::kfe_sums_t       fin_q, fin_d;

  logic                     is_gene, in_range, idx_ok, ram_we, ram_re;
  logic [31:0]              idx32, gp32, w32, v32;
  logic [IDX_W-1:0]         ram_addr;
  logic [WEIGHT_BITS-1:0]   w_rd, w_add;
  logic [VALUE_BITS-1:0]    v_rd, v_add;
  logic [WADD_W-1:0]        wsum_full;
  logic [VADD_W-1:0]        vsum_full;
  logic [kfe_pkg::SUM_W-1:0] wsum_new, vsum_new;

  assign is_gene  = (cmd_i == kfe_pkg::CMD_GENE);
  assign idx32    = 32'(item_index_i);
  assign gp32     = 32'(gp_q);
  assign w32      = 32'(item_weight_i);
  assign v32      = 32'(item_value_i);
  assign idx_ok   = (idx32 < 32'(MAX_ITEMS));
  assign in_range = (gp32 < 32'(MAX_ITEMS));
  assign ram_we   = acc_i && !is_gene && idx_ok;
  assign ram_re   = acc_i && is_gene && in_range;
  assign ram_addr = is_gene ? gp32[IDX_W-1:0] : idx32[IDX_W-1:0];

  kfe_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (w32[WEIGHT_BITS-1:0]),
    .rdata_o (w_rd)
  );

  kfe_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (v32[VALUE_BITS-1:0]),
    .rdata_o (v_rd)
  );

  // gene position advances at acceptance, stops at the table end, clears on last gene
  always_comb begin
    gp_d = gp_q;
    if (acc_i && is_gene) begin
      if (last_gene_i) begin
        gp_d = '0;
      end else if (in_range) begin
        gp_d = gp_q + GP_W'(1);
      end
    end
  end

  // saturating accumulation of table data read for the previous gene
  assign w_add     = s1_gene_q ? w_rd : '0;
  assign v_add     = s1_gene_q ? v_rd : '0;
  assign wsum_full = WADD_W'(wsum_q) + WADD_W'(w_add);
  assign vsum_full = VADD_W'(vsum_q) + VADD_W'(v_add);
  assign wsum_new  = (wsum_full > WADD_W'(kfe_pkg::SUM_MAX)) ?
                     kfe_pkg::SUM_MAX : wsum_full[kfe_pkg::SUM_W-1:0];
  assign vsum_new  = (vsum_full > VADD_W'(kfe_pkg::SUM_MAX)) ?
                     kfe_pkg::SUM_MAX : vsum_full[kfe_pkg::SUM_W-1:0];

  always_comb begin
    wsum_d            = wsum_q;
    vsum_d            = vsum_q;
    fin_valid_d       = 1'b0;
    fin_d.weight      = wsum_new;
    fin_d.value       = vsum_new;
    fin_d.last_chrom  = s1_last_chrom_q;
    if (s1_valid_q) begin
      if (s1_last_gene_q) begin
        wsum_d      = '0;
        vsum_d      = '0;
        fin_valid_d = 1'b1;
      end else begin
        wsum_d = wsum_new;
        vsum_d = vsum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q        <= '0;
      s1_valid_q  <= 1'b0;
      wsum_q      <= '0;
      vsum_q      <= '0;
      fin_valid_q <= 1'b0;
    end else if (en_i) begin
      gp_q        <= gp_d;
      s1_valid_q  <= acc_i && is_gene;
      wsum_q      <= wsum_d;
      vsum_q      <= vsum_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_gene_q       <= gene_i && in_range;
      s1_last_gene_q  <= last_gene_i;
      s1_last_chrom_q <= last_chromosome_i;
      fin_q           <= fin_d;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

[src/kfe_score.sv]
// chromosome scoring, population best and total, result register
module kfe_score (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         fin_valid_i,
  input  kfe_pkg::kfe_sums_t           fin_i,
  input  logic [kfe_pkg::SUM_W-1:0]    capacity_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [kfe_pkg::SUM_W-1:0]    chrom_score_o,
  output logic                         overweight_o,
  output logic [kfe_pkg::SUM_W-1:0]    best_score_o,
  output logic [kfe_pkg::TOTAL_W-1:0]  total_score_o,
  output logic                         population_done_o
);

  logic [kfe_pkg::SUM_W-1:0]   best_q, best_d, best_new, score;
  logic [kfe_pkg::TOTAL_W-1:0] total_q, total_d, total_new;
  logic [kfe_pkg::TOTAL_W:0]   total_full;
  logic                        over, load;
  logic                        out_valid_q, out_valid_d;
  logic [kfe_pkg::SUM_W-1:0]   score_q, best_out_q;
  logic [kfe_pkg::TOTAL_W-1:0] total_out_q;
  logic                        over_q, done_q;

  assign load       = en_i && fin_valid_i;
  assign over       = (fin_i.weight > capacity_i);
  assign score      = over ? kfe_pkg::PENALTY_SCORE : fin_i.value;
  assign total_full = (kfe_pkg::TOTAL_W + 1)'(total_q) + (kfe_pkg::TOTAL_W + 1)'(score);
  assign total_new  = total_full[kfe_pkg::TOTAL_W] ?
                      kfe_pkg::TOTAL_MAX : total_full[kfe_pkg::TOTAL_W-1:0];
  assign best_new   = (score > best_q) ? score : best_q;

  always_comb begin
    best_d      = best_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (fin_i.last_chrom) begin
        best_d  = '0;
        total_d = '0;
      end else begin
        best_d  = best_new;
        total_d = total_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      score_q     <= score;
      over_q      <= over;
      best_out_q  <= best_new;
      total_out_q <= total_new;
      done_q      <= fin_i.last_chrom;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chrom_score_o     = score_q;
  assign overweight_o      = over_q;
  assign best_score_o      = best_out_q;
  assign total_score_o     = total_out_q;
  assign population_done_o = done_q;

endmodule
